@@ hw/rtl/plist_pkg.sv @@
`timescale 1ns / 1ps

package plist_pkg;

  localparam int DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

  typedef struct packed {
    logic op_load;
    logic dump_start;
    logic ent_load;
    logic term_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic dump_more;
  } dp_status_t;

endpackage

@@ hw/rtl/plist_ctrl.sv @@
`timescale 1ns / 1ps

module plist_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [1:0]             in_cmd,
  output logic                   in_stall,
  input  plist_pkg::dp_status_t  sts,
  output plist_pkg::ctrl_cmd_t   cmd
);

  plist_pkg::state_t state_r;
  plist_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plist_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_stall       = 1'b1;
    cmd.op_load    = 1'b0;
    cmd.dump_start = 1'b0;
    cmd.ent_load   = 1'b0;
    cmd.term_load  = 1'b0;
    case (state_r)
      plist_pkg::S_IDLE: begin
        in_stall = !sts.out_free;
        if (in_valid && sts.out_free) begin
          if (in_cmd == plist_pkg::CMD_DUMP) begin
            cmd.dump_start = 1'b1;
            state_nxt      = plist_pkg::S_DUMP;
          end else begin
            cmd.op_load = 1'b1;
          end
        end
      end
      plist_pkg::S_DUMP: begin
        if (sts.out_free) begin
          if (sts.dump_more) begin
            cmd.ent_load = 1'b1;
          end else begin
            cmd.term_load = 1'b1;
            state_nxt     = plist_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = plist_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/plist_dpath.sv @@
`timescale 1ns / 1ps

module plist_dpath #(
  parameter int DEPTH = plist_pkg::DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  plist_pkg::ctrl_cmd_t   cmd,
  output plist_pkg::dp_status_t  sts,
  input  logic [1:0]             in_cmd,
  input  logic [5:0]             in_position,
  input  logic signed [31:0]     in_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_status,
  output logic [4:0]             out_count,
  output logic                   out_has_entry,
  output logic signed [31:0]     out_entry_value,
  output logic                   out_last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int XW = CW + 7;

  logic signed [31:0] cells_r   [DEPTH];
  logic signed [31:0] cells_nxt [DEPTH];
  logic [CW-1:0]      cnt_r;
  logic [CW-1:0]      cnt_nxt;
  logic [CW-1:0]      idx_r;
  logic [CW-1:0]      idx_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [1:0]         out_status_r;
  logic [1:0]         out_status_nxt;
  logic [4:0]         out_count_r;
  logic [4:0]         out_count_nxt;
  logic               out_has_entry_r;
  logic               out_has_entry_nxt;
  logic signed [31:0] out_value_r;
  logic signed [31:0] out_value_nxt;
  logic               out_last_r;
  logic               out_last_nxt;

  logic [XW-1:0]      pos_x;
  logic [XW-1:0]      pos_m1;
  logic [XW-1:0]      cnt_x;
  logic               ins_en;
  logic               del_en;
  plist_pkg::status_t op_status;
  logic [CW+4:0]      cnt_nxt_ext;
  logic               load_any;

  assign pos_x       = XW'(in_position);
  assign pos_m1      = pos_x - XW'(1);
  assign cnt_x       = XW'(cnt_r);
  assign cnt_nxt_ext = {5'b0, cnt_nxt};
  assign load_any    = cmd.op_load | cmd.ent_load | cmd.term_load;

  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.dump_more = idx_r < cnt_r;

  always_comb begin
    op_status = plist_pkg::ST_OK;
    ins_en    = 1'b0;
    del_en    = 1'b0;
    cnt_nxt   = cnt_r;
    if (cmd.op_load) begin
      case (in_cmd)
        plist_pkg::CMD_INSERT: begin
          if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
            op_status = plist_pkg::ST_RANGE;
          end else if (cnt_r == CW'(DEPTH)) begin
            op_status = plist_pkg::ST_FULL;
          end else begin
            ins_en  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        plist_pkg::CMD_DELETE: begin
          if (pos_x == '0 || pos_x > cnt_x) begin
            op_status = plist_pkg::ST_RANGE;
          end else begin
            del_en  = 1'b1;
            cnt_nxt = cnt_r - CW'(1);
          end
        end
        default: begin
          op_status = plist_pkg::ST_OK;
        end
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] prev_w;
    logic signed [31:0] next_w;
    if (g == 0) begin : g_first
      assign prev_w = cells_r[g];
    end else begin : g_mid_lo
      assign prev_w = cells_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_w = cells_r[g];
    end else begin : g_mid_hi
      assign next_w = cells_r[g+1];
    end
    assign cells_nxt[g] = (ins_en && XW'(g) == pos_m1) ? in_value :
                          (ins_en && XW'(g) >  pos_m1) ? prev_w   :
                          (del_en && XW'(g) >= pos_m1) ? next_w   :
                                                         cells_r[g];
  end

  always_comb begin
    idx_nxt           = idx_r;
    out_valid_nxt     = out_valid_r;
    out_status_nxt    = out_status_r;
    out_count_nxt     = out_count_r;
    out_has_entry_nxt = out_has_entry_r;
    out_value_nxt     = out_value_r;
    out_last_nxt      = out_last_r;
    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.dump_start) begin
      idx_nxt = '0;
    end
    if (load_any) begin
      out_valid_nxt     = 1'b1;
      out_count_nxt     = cnt_nxt_ext[4:0];
      out_status_nxt    = plist_pkg::ST_OK;
      out_has_entry_nxt = 1'b0;
      out_value_nxt     = '0;
      out_last_nxt      = 1'b1;
    end
    if (cmd.op_load) begin
      out_status_nxt = op_status;
    end
    if (cmd.ent_load) begin
      out_has_entry_nxt = 1'b1;
      out_value_nxt     = cells_r[idx_r[IW-1:0]];
      out_last_nxt      = 1'b0;
      idx_nxt           = idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cells_r         <= cells_nxt;
    out_status_r    <= out_status_nxt;
    out_count_r     <= out_count_nxt;
    out_has_entry_r <= out_has_entry_nxt;
    out_value_r     <= out_value_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_count       = out_count_r;
  assign out_has_entry   = out_has_entry_r;
  assign out_entry_value = out_value_r;
  assign out_last        = out_last_r;

endmodule

@@ hw/rtl/positional_list_engine_core.sv @@
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// in       in_valid, in_stall   in_cmd, in_position, in_value
// out      out_valid, out_stall out_status, out_count, out_has_entry,
//                               out_entry_value, out_last
//
// A non-dump command is taken at one transfer and its result stands in the output
// register the next cycle; a valid insert or delete moves cells from its position on.
// A dump holds in_stall high from its transfer until its terminator is loaded,
// one result a cycle unless out_stall holds it, through the single output register.
// The synchronous active-low reset empties the list; the cells are not cleared.
// While a result waits under out_stall it holds and no further input is taken.

module positional_list_engine_core #(
  parameter int DEPTH = plist_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [5:0]         in_position,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [4:0]         out_count,
  output logic               out_has_entry,
  output logic signed [31:0] out_entry_value,
  output logic               out_last
);

  plist_pkg::ctrl_cmd_t  cmd;
  plist_pkg::dp_status_t sts;

  plist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  plist_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_cmd          (in_cmd),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_count       (out_count),
    .out_has_entry   (out_has_entry),
    .out_entry_value (out_entry_value),
    .out_last        (out_last)
  );

  a_op_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_cmd != plist_pkg::CMD_DUMP)
      |=> (out_valid && out_last && !out_has_entry))
    else $error("insert or delete transfer did not produce a final result");

  a_dump_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_cmd == plist_pkg::CMD_DUMP) |=> in_stall)
    else $error("input taken while a dump is in progress");

  a_entry_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_entry) |-> (!out_last && out_status == plist_pkg::ST_OK))
    else $error("dumped entry carries last or a nonzero status");

  a_no_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_entry) |-> (out_entry_value == '0 && out_last))
    else $error("result without an entry is not a zero final result");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int LIST_DEPTH = plist_pkg::DEPTH_DEF;
  localparam logic [1:0] CMD_UNDEF = 2'd3;

  typedef struct packed {
    plist_pkg::status_t status;
    logic [4:0]         entry_count;
    logic               has_entry;
    logic signed [31:0] entry_value;
    logic               last_flag;
  } list_result_t;

  typedef struct {
    logic [1:0]         cmd;
    logic [5:0]         pos;
    logic signed [31:0] value;
    int                 reps;
    bit                 typed;
    plist_pkg::status_t t_status;
    logic [4:0]         t_count;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_cmd;
  logic [5:0]         in_position;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic [4:0]         out_count;
  logic               out_has_entry;
  logic signed [31:0] out_entry_value;
  logic               out_last;

  logic signed [31:0] list_cells[$];
  list_result_t       new_results[$];
  list_result_t       pending_results[$];
  stim_row_t          directed_rows[$];
  list_result_t       exp_r;
  list_result_t       typed_r;

  bit                 cur_typed;
  plist_pkg::status_t cur_t_status;
  logic [4:0]         cur_t_count;
  bit                 idle_on;
  bit                 hold_req;
  int                 hold_left;
  int                 stall_left;
  int                 mismatches;

  positional_list_engine_core #(
    .DEPTH(LIST_DEPTH)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_count      (out_count),
    .out_has_entry  (out_has_entry),
    .out_entry_value(out_entry_value),
    .out_last       (out_last)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] expv,
                                 input logic [63:0] gotv);
    mismatches++;
    if (mismatches <= 100) begin
      $display("MISMATCH at %0t: %s expected %0h got %0h", $realtime, what, expv, gotv);
    end
  endtask

  function automatic list_result_t make_result(plist_pkg::status_t st, logic has,
                                               logic signed [31:0] v, logic fin);
    list_result_t r;
    r.status      = st;
    r.entry_count = 5'(list_cells.size());
    r.has_entry   = has;
    r.entry_value = has ? v : 32'sd0;
    r.last_flag   = fin;
    return r;
  endfunction

  task automatic apply_list_op(input logic [1:0] cmd, input logic [5:0] pos,
                               input logic signed [31:0] val);
    int n;
    plist_pkg::status_t st;
    n = list_cells.size();
    new_results.delete();
    case (cmd)
      plist_pkg::CMD_INSERT: begin
        if (pos == 0 || pos > n + 1) begin
          st = plist_pkg::ST_RANGE;
        end else if (n >= LIST_DEPTH) begin
          st = plist_pkg::ST_FULL;
        end else begin
          list_cells.insert(pos - 1, val);
          st = plist_pkg::ST_OK;
        end
        new_results.push_back(make_result(st, 1'b0, 32'sd0, 1'b1));
      end
      plist_pkg::CMD_DELETE: begin
        if (pos == 0 || pos > n) begin
          st = plist_pkg::ST_RANGE;
        end else begin
          list_cells.delete(pos - 1);
          st = plist_pkg::ST_OK;
        end
        new_results.push_back(make_result(st, 1'b0, 32'sd0, 1'b1));
      end
      plist_pkg::CMD_DUMP: begin
        foreach (list_cells[i]) begin
          new_results.push_back(make_result(plist_pkg::ST_OK, 1'b1, list_cells[i], 1'b0));
        end
        new_results.push_back(make_result(plist_pkg::ST_OK, 1'b0, 32'sd0, 1'b1));
      end
      default: begin
        new_results.push_back(make_result(plist_pkg::ST_OK, 1'b0, 32'sd0, 1'b1));
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        apply_list_op(in_cmd, in_position, in_value);
        if (cur_typed) begin
          typed_r.status      = cur_t_status;
          typed_r.entry_count = cur_t_count;
          typed_r.has_entry   = 1'b0;
          typed_r.entry_value = 32'sd0;
          typed_r.last_flag   = 1'b1;
          pending_results.push_back(typed_r);
        end else begin
          foreach (new_results[i]) pending_results.push_back(new_results[i]);
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, status", 64'd0, 64'(out_status));
        end else begin
          exp_r = pending_results.pop_front();
          if (out_status != exp_r.status)
            report_mismatch("status", 64'(exp_r.status), 64'(out_status));
          if (out_count != exp_r.entry_count)
            report_mismatch("count", 64'(exp_r.entry_count), 64'(out_count));
          if (out_has_entry != exp_r.has_entry)
            report_mismatch("has_entry", 64'(exp_r.has_entry), 64'(out_has_entry));
          if (out_entry_value != exp_r.entry_value)
            report_mismatch("entry_value", 64'(exp_r.entry_value),
                            64'(out_entry_value));
          if (out_last != exp_r.last_flag)
            report_mismatch("last", 64'(exp_r.last_flag), 64'(out_last));
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 150;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      out_stall  = (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  task automatic add_row(input logic [1:0] cmd, input logic [5:0] pos,
                         input logic signed [31:0] value, input int reps,
                         input bit typed, input plist_pkg::status_t t_status,
                         input logic [4:0] t_count);
    stim_row_t row;
    row.cmd      = cmd;
    row.pos      = pos;
    row.value    = value;
    row.reps     = reps;
    row.typed    = typed;
    row.t_status = t_status;
    row.t_count  = t_count;
    directed_rows.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic [1:0] cmd, input logic [5:0] pos,
                           input logic signed [31:0] val, input bit typed,
                           input plist_pkg::status_t t_status,
                           input logic [4:0] t_count);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_cmd       = cmd;
    in_position  = pos;
    in_value     = val;
    cur_typed    = typed;
    cur_t_status = t_status;
    cur_t_count  = t_count;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic gen_random_item(input bit grow, output logic [1:0] cmd,
                                 output logic [5:0] pos,
                                 output logic signed [31:0] val);
    int n;
    int r;
    n   = list_cells.size();
    r   = $urandom_range(0, 99);
    pos = 6'($urandom_range(0, 63));
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       val = 32'sh7fff_ffff;
        1:       val = 32'sh8000_0000;
        2:       val = 32'sd0;
        default: val = -32'sd1;
      endcase
    end else begin
      val = $urandom;
    end
    if (r < 3) begin
      cmd = CMD_UNDEF;
    end else if (r < 13) begin
      cmd = plist_pkg::CMD_DUMP;
    end else if (r < 20) begin
      cmd = $urandom_range(0, 1) ? plist_pkg::CMD_DELETE : plist_pkg::CMD_INSERT;
    end else if (n == 0 || $urandom_range(0, 99) < (grow ? 75 : 30)) begin
      cmd = plist_pkg::CMD_INSERT;
      pos = 6'($urandom_range(1, n + 1));
    end else begin
      cmd = plist_pkg::CMD_DELETE;
      pos = 6'($urandom_range(1, n));
    end
  endtask

  initial begin
    stim_row_t          row;
    logic [1:0]         cmd;
    logic [5:0]         pos;
    logic signed [31:0] val;
    int                 c;
    int                 k;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_cmd       = plist_pkg::CMD_INSERT;
    in_position  = 6'd0;
    in_value     = 32'sd0;
    out_stall    = 1'b0;
    cur_typed    = 1'b0;
    cur_t_status = plist_pkg::ST_OK;
    cur_t_count  = 5'd0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    hold_left    = 0;
    stall_left   = 0;
    mismatches   = 0;

    add_row(plist_pkg::CMD_DUMP,   6'd0,  32'sd0,         1,  1'b1, plist_pkg::ST_OK,    5'd0);
    add_row(plist_pkg::CMD_DELETE, 6'd1,  32'sd0,         1,  1'b1, plist_pkg::ST_RANGE, 5'd0);
    add_row(plist_pkg::CMD_INSERT, 6'd0,  32'sd7,         1,  1'b1, plist_pkg::ST_RANGE, 5'd0);
    add_row(plist_pkg::CMD_INSERT, 6'd2,  32'sd7,         1,  1'b1, plist_pkg::ST_RANGE, 5'd0);
    add_row(plist_pkg::CMD_INSERT, 6'd1,  32'sh7fff_ffff, 1,  1'b1, plist_pkg::ST_OK,    5'd1);
    add_row(plist_pkg::CMD_DELETE, 6'd1,  32'sd0,         1,  1'b1, plist_pkg::ST_OK,    5'd0);
    add_row(plist_pkg::CMD_INSERT, 6'd1,  32'sh8000_0000, 1,  1'b1, plist_pkg::ST_OK,    5'd1);
    add_row(plist_pkg::CMD_INSERT, 6'd2,  -32'sd1,        1,  1'b1, plist_pkg::ST_OK,    5'd2);
    add_row(plist_pkg::CMD_INSERT, 6'd1,  32'sd0,         1,  1'b1, plist_pkg::ST_OK,    5'd3);
    add_row(plist_pkg::CMD_INSERT, 6'd63, 32'sd1,         1,  1'b1, plist_pkg::ST_RANGE, 5'd3);
    add_row(plist_pkg::CMD_DELETE, 6'd0,  32'sd0,         1,  1'b1, plist_pkg::ST_RANGE, 5'd3);
    add_row(plist_pkg::CMD_DELETE, 6'd4,  32'sd0,         1,  1'b1, plist_pkg::ST_RANGE, 5'd3);
    add_row(CMD_UNDEF,             6'd63, -32'sd1,        1,  1'b1, plist_pkg::ST_OK,    5'd3);
    add_row(plist_pkg::CMD_DUMP,   6'd63, 32'sd0,         1,  1'b0, plist_pkg::ST_OK,    5'd0);
    add_row(plist_pkg::CMD_DELETE, 6'd2,  32'sd0,         1,  1'b1, plist_pkg::ST_OK,    5'd2);
    add_row(plist_pkg::CMD_INSERT, 6'd1,  32'sh5555_5555, 14, 1'b0, plist_pkg::ST_OK,    5'd0);
    add_row(plist_pkg::CMD_INSERT, 6'd17, 32'sd9,         1,  1'b1, plist_pkg::ST_FULL,  5'd16);
    add_row(plist_pkg::CMD_INSERT, 6'd18, 32'sd9,         1,  1'b1, plist_pkg::ST_RANGE, 5'd16);
    add_row(plist_pkg::CMD_INSERT, 6'd1,  32'sd9,         1,  1'b1, plist_pkg::ST_FULL,  5'd16);
    add_row(plist_pkg::CMD_DUMP,   6'd0,  32'sd0,         1,  1'b0, plist_pkg::ST_OK,    5'd0);
    add_row(plist_pkg::CMD_DELETE, 6'd16, 32'sd0,         1,  1'b1, plist_pkg::ST_OK,    5'd15);
    add_row(plist_pkg::CMD_DELETE, 6'd1,  32'sd0,         1,  1'b1, plist_pkg::ST_OK,    5'd14);
    add_row(plist_pkg::CMD_INSERT, 6'd15, 32'shaaaa_aaaa, 1,  1'b1, plist_pkg::ST_OK,    5'd15);
    add_row(plist_pkg::CMD_DUMP,   6'd0,  32'sd0,         1,  1'b0, plist_pkg::ST_OK,    5'd0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      for (k = 0; k < row.reps; k++) begin
        send_item(row.cmd, row.pos, row.value + k, row.typed, row.t_status, row.t_count);
      end
    end

    for (c = 0; c < 6; c++) begin
      idle_on = (c != 3);
      if (c == 1) hold_req = 1'b1;
      for (k = 0; k < 50; k++) begin
        gen_random_item(c % 2 == 0, cmd, pos, val);
        send_item(cmd, pos, val, 1'b0, plist_pkg::ST_OK, 5'd0);
      end
      if (c == 2) begin
        while (pending_results.size() != 0) @(posedge clk);
        @(negedge clk);
      end
    end
    in_valid = 1'b0;
    idle_on  = 1'b1;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
